### rtl/slte_pkg.sv
// Shared constants and types of the sorted list table engine.
`timescale 1ns / 1ps
`default_nettype none

package slte_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int FIELD_W  = 7;
   localparam int RSP_DATA_W = ((2 * FIELD_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_FIND    = 2'd2,
      OP_REVERSE = 2'd3
   } op_type;

   typedef logic [CNT_W-1:0] count_type;

endpackage

`default_nettype wire

### rtl/slte_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module slte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/sorted_list_table_engine.sv
// Top level of the sorted list table engine: operation sequencer around the entry RAM.
//
//   channel  direction  tdata                                  tuser
//   req      in         [31:0] value                           [1:0] func
//   rsp      out        [6:0] position, [13:7] length, pad 0   [0] status
//
// Insert, remove and find walk the list one stored entry at a time (RAM read, read
// data, then compare and write back), then do the end check, the response and the
// return to idle; reverse swaps one pair at a time, reading both ends and writing
// both back. Requests are taken only in idle. Reset clears the length and the
// response valid; the entries need no clearing. A stalled response holds, and the
// next item is taken while it waits, but its result waits behind it.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_table_engine (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [slte_pkg::VALUE_W-1:0]   req_tdata,  // [31:0] value
   input  wire logic [1:0]                     req_tuser,  // [1:0] func
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [slte_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [6:0] position, [13:7] length
   output logic [0:0]                          rsp_tuser   // [0] status
);

   import slte_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_PROC,
      ST_REV_A,
      ST_REV_B,
      ST_REV_C,
      ST_REV_D,
      ST_DONE
   } state_type;

   state_type                  state_ff, state_in;
   op_type                     op_ff, op_in;
   logic signed [VALUE_W-1:0]  value_ff, value_in;
   logic        [VALUE_W-1:0]  carry_ff, carry_in;
   count_type                  count_ff, count_in;
   count_type                  idx_ff, idx_in;
   count_type                  hi_ff, hi_in;
   count_type                  pos_ff, pos_in;
   logic                       found_ff, found_in;
   logic                       reject_ff, reject_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                       rsp_status_ff, rsp_status_in;

   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [VALUE_W-1:0]         wr_data;
   logic                       rd_en;
   logic [ADDR_W-1:0]          rd_addr;
   logic [VALUE_W-1:0]         rd_data;
   logic                       accept;
   logic                       rsp_free;

   slte_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      carry_in      = carry_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      hi_in         = hi_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      reject_in     = reject_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[ADDR_W-1:0];
      wr_data       = carry_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[ADDR_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = op_type'(req_tuser);
               value_in  = $signed(req_tdata);
               carry_in  = req_tdata;
               idx_in    = '0;
               hi_in     = count_ff;
               pos_in    = '0;
               found_in  = 1'b0;
               reject_in = 1'b0;
               state_in  = (op_type'(req_tuser) == OP_REVERSE) ? ST_REV_A : ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (op_ff == OP_INSERT && count_ff >= CNT_W'(CAPACITY)) begin
               reject_in = 1'b1;
               state_in  = ST_DONE;
            end else if (idx_ff == count_ff) begin
               // End of the list: an insert always lands its carried value here.
               if (op_ff == OP_INSERT) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else if (op_ff == OP_REMOVE && found_ff) begin
                  count_in = count_ff - CNT_W'(1);
               end
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_PROC;
         end
         ST_PROC: begin
            idx_in   = idx_ff + CNT_W'(1);
            state_in = ST_CHECK;
            if (op_ff == OP_INSERT) begin
               // From the first entry greater than the value on, every entry moves up one.
               if (found_ff || ($signed(rd_data) > value_ff)) begin
                  wr_en    = 1'b1;
                  carry_in = rd_data;
                  found_in = 1'b1;
               end
            end else if (found_ff) begin
               if (op_ff == OP_REMOVE) begin
                  wr_en   = 1'b1;
                  wr_addr = ADDR_W'(idx_ff - CNT_W'(1));
                  wr_data = rd_data;
               end
            end else if (rd_data == value_ff) begin
               found_in = 1'b1;
               pos_in   = idx_ff + CNT_W'(1);
               if (op_ff == OP_FIND) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_REV_A: begin
            if (idx_ff + CNT_W'(1) < hi_ff) begin
               rd_en    = 1'b1;
               state_in = ST_REV_B;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_REV_B: begin
            carry_in = rd_data;
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(hi_ff - CNT_W'(1));
            state_in = ST_REV_C;
         end
         ST_REV_C: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            state_in = ST_REV_D;
         end
         ST_REV_D: begin
            wr_en    = 1'b1;
            wr_addr  = ADDR_W'(hi_ff - CNT_W'(1));
            idx_in   = idx_ff + CNT_W'(1);
            hi_in    = hi_ff - CNT_W'(1);
            state_in = ST_REV_A;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = reject_ff;
               rsp_data_in   = '0;
               rsp_data_in[FIELD_W-1:0]         = FIELD_W'(pos_ff);
               rsp_data_in[2*FIELD_W-1:FIELD_W] = FIELD_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      value_ff      <= value_in;
      carry_ff      <= carry_in;
      idx_ff        <= idx_in;
      hi_ff         <= hi_in;
      pos_ff        <= pos_in;
      found_ff      <= found_in;
      reject_ff     <= reject_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_status_ff;

endmodule

`default_nettype wire

### rtl/slte_checker.sv
// Port-level checker for the sorted list table engine and its bind.
`timescale 1ns / 1ps
`default_nettype none

module slte_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [slte_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire logic [0:0]                         rsp_tuser
);

   import slte_pkg::*;

   logic [FIELD_W-1:0] position;
   logic [FIELD_W-1:0] length;

   assign position = rsp_tdata[FIELD_W-1:0];
   assign length   = rsp_tdata[2*FIELD_W-1:FIELD_W];

   // A stalled response item holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response item changed");

   // A rejected insert reports no position and a full store.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> position == '0 && length == FIELD_W'(CAPACITY))
      else $error("rejected insert with wrong position or length");

   // The length never passes the capacity, and a position lies at most one past the length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> length <= FIELD_W'(CAPACITY) && {1'b0, position} <= {1'b0, length} + 1'b1)
      else $error("length or position out of range");

   // Reset empties the response register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind sorted_list_table_engine slte_checker u_slte_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
